// File: rtl/ssbp_pkg.sv
// Shared types and constants for the sample sort bucket partitioner.
// No dependencies; the front end, back end, top level and checker import this package.
`timescale 1ns / 1ps

package ssbp_pkg;

   localparam int DATA_W       = 32;
   localparam int BKT_W        = 5;
   localparam int BCNT_W       = 6;
   localparam int BUCKET_LIMIT = 32;
   localparam int MID_DEPTH    = 4;
   localparam int OUT_DEPTH    = 4;
   localparam int CSR_AW       = 2;

   localparam logic [CSR_AW-1:0] CSR_ADDR_BUCKET_COUNT = 2'd0;
   localparam logic [BCNT_W-1:0] BCNT_RESET            = 6'd4;

   localparam logic KIND_CLASSIFY = 1'b0;
   localparam logic KIND_REPORT   = 1'b1;

   typedef enum logic [1:0] {
      MODE_LOAD     = 2'd0,
      MODE_CLASSIFY = 2'd1,
      MODE_REPORT   = 2'd2
   } mode_type;

   // Job passed from the classifier to the counter engine
   typedef struct packed {
      logic             is_report;
      logic [BKT_W-1:0] bucket;
   } job_type;

   typedef struct packed {
      logic              kind;
      logic [BKT_W-1:0]  bucket;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] offset;
      logic              last;
   } rsp_item_type;

endpackage

// File: rtl/ssbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssbp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ssbp_fifo.sv
// Small register-based queue used between the partitioner stages and at the output.
// No dependencies.
`timescale 1ns / 1ps

module ssbp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/ssbp_front.sv
// Front end: splitter table, comparator bank and priority encoder.
// Accepts items, turns classify and report items into jobs. Uses ssbp_pkg.
`timescale 1ns / 1ps

module ssbp_front
   import ssbp_pkg::*;
#(
   parameter int NUM_SPL = 31,
   parameter int CNT_AW  = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_mode,
   input  logic [BKT_W-1:0]  req_splitter_index,
   input  logic [DATA_W-1:0] req_value,
   input  logic [CNT_AW-1:0] last_bkt,
   output logic              job_push,
   input  logic              job_full,
   output job_type           job
);

   localparam int SPL_AW = (NUM_SPL > 1) ? $clog2(NUM_SPL) : 1;

   logic [DATA_W-1:0]  spl_ff [NUM_SPL];
   logic [NUM_SPL-1:0] hit_ff, hit_in;
   logic               stg_valid_ff, stg_valid_in;
   logic               stg_report_ff;
   logic               accept, new_stg, spl_wr;
   logic [CNT_AW-1:0]  enc_bkt;

   assign req_full = stg_valid_ff && job_full;
   assign accept   = req_push && !req_full;
   assign new_stg  = accept && (req_mode == MODE_CLASSIFY || req_mode == MODE_REPORT);
   assign spl_wr   = accept && (req_mode == MODE_LOAD)
                     && (req_splitter_index < BKT_W'(NUM_SPL));
   assign job_push = stg_valid_ff && !job_full;

   // Compare against the table as it stands at acceptance
   always_comb begin
      for (int i = 0; i < NUM_SPL; i++) begin
         hit_in[i] = (CNT_AW'(i) < last_bkt) && (req_value <= spl_ff[i]);
      end
   end

   // Lowest matching splitter wins; no match goes to the last bucket
   always_comb begin
      enc_bkt = last_bkt;
      for (int i = NUM_SPL - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            enc_bkt = CNT_AW'(i);
         end
      end
   end

   assign job.is_report = stg_report_ff;
   assign job.bucket    = BKT_W'(enc_bkt);

   assign stg_valid_in = new_stg || (stg_valid_ff && !job_push);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (new_stg) begin
         hit_ff        <= hit_in;
         stg_report_ff <= (req_mode == MODE_REPORT);
      end
      if (spl_wr) begin
         spl_ff[req_splitter_index[SPL_AW-1:0]] <= req_value;
      end
   end

endmodule

// File: rtl/ssbp_back.sv
// Back end: bucket counter engine with report sequencer.
// Uses ssbp_pkg and one ssbp_ram for the counters.
`timescale 1ns / 1ps

module ssbp_back
   import ssbp_pkg::*;
#(
   parameter int USE_BUCKETS = 32,
   parameter int CNT_AW      = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_AW-1:0] last_bkt,
   input  logic              job_empty,
   output logic              job_pop,
   input  job_type           job,
   input  logic              out_full,
   output logic              out_push,
   output rsp_item_type      out_item
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CLS  = 3'b010,
      S_RPT  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_AW-1:0]      k_ff, k_in;
   logic [DATA_W-1:0]      off_ff, off_in;
   logic [USE_BUCKETS-1:0] valid_ff, valid_in;

   logic              rd_en, wr_en;
   logic [CNT_AW-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data, cnt_cur, cnt_inc;
   logic [DATA_W:0]   off_sum;
   logic              is_last;

   ssbp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (USE_BUCKETS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (k_ff),
      .wr_data (cnt_inc),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A counter not touched since the last report reads as zero
   assign cnt_cur = valid_ff[k_ff] ? rd_data : '0;
   assign cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + DATA_W'(1);
   assign off_sum = {1'b0, off_ff} + {1'b0, cnt_cur};
   assign is_last = (k_ff == last_bkt);

   always_comb begin
      out_item.bucket = BKT_W'(k_ff);
      out_item.count  = cnt_cur;
      if (state_ff == S_RPT) begin
         out_item.kind   = KIND_REPORT;
         out_item.offset = off_ff;
         out_item.last   = is_last;
      end else begin
         out_item.kind   = KIND_CLASSIFY;
         out_item.offset = '0;
         out_item.last   = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      off_in   = off_ff;
      valid_in = valid_ff;
      job_pop  = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = k_ff;
      wr_en    = 1'b0;
      out_push = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               rd_en   = 1'b1;
               if (job.is_report) begin
                  k_in     = '0;
                  rd_addr  = '0;
                  off_in   = '0;
                  state_in = S_RPT;
               end else begin
                  k_in     = job.bucket[CNT_AW-1:0];
                  rd_addr  = job.bucket[CNT_AW-1:0];
                  state_in = S_CLS;
               end
            end
         end
         S_CLS: begin
            if (!out_full) begin
               out_push       = 1'b1;
               wr_en          = 1'b1;
               valid_in[k_ff] = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_RPT: begin
            if (!out_full) begin
               out_push = 1'b1;
               off_in   = off_sum[DATA_W] ? '1 : off_sum[DATA_W-1:0];
               if (is_last) begin
                  valid_in = '0;
                  state_in = S_IDLE;
               end else begin
                  k_in    = k_ff + CNT_AW'(1);
                  rd_en   = 1'b1;
                  rd_addr = k_ff + CNT_AW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      off_ff <= off_in;
   end

endmodule

// File: rtl/sample_sort_bucket_partitioner_top.sv
// Sample sort bucket partitioner. A classify result reaches rsp through the comparator
// stage register, the job queue, the counter RAM read and the result queue; the counter
// engine takes a new classify only after the read-then-write of the counter RAM. A
// report gives one entry per cycle while the result queue has room, one per bucket in
// use. Reset (synchronous) empties the queues, zeroes all counters through per-bucket
// valid bits and sets bucket_count to 4; the splitter table holds garbage until loaded.
`timescale 1ns / 1ps

module sample_sort_bucket_partitioner_top
   import ssbp_pkg::*;
#(
   parameter int MAX_BUCKETS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_mode,
   input  logic [BKT_W-1:0]  req_splitter_index,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_kind,
   output logic [BKT_W-1:0]  rsp_bucket,
   output logic [DATA_W-1:0] rsp_count,
   output logic [DATA_W-1:0] rsp_offset,
   output logic              rsp_last,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int USE_BUCKETS = (MAX_BUCKETS < BUCKET_LIMIT) ? MAX_BUCKETS : BUCKET_LIMIT;
   localparam int NUM_SPL     = USE_BUCKETS - 1;
   localparam int CNT_AW      = $clog2(USE_BUCKETS);

   logic [BCNT_W-1:0] bucket_count_ff, bucket_count_in;
   logic [CNT_AW-1:0] last_bkt;
   logic              csr_wr;

   job_type      job_wr, job_rd;
   logic         job_push, job_full, job_pop, job_empty;
   rsp_item_type out_wr, out_rd;
   logic         out_push, out_full;

   // Control and status
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == CSR_ADDR_BUCKET_COUNT);
   assign csr_prdata = (csr_paddr == CSR_ADDR_BUCKET_COUNT) ? 32'(bucket_count_ff) : '0;
   assign bucket_count_in = csr_wr ? csr_pwdata[BCNT_W-1:0] : bucket_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BCNT_RESET;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   // Clamp the bucket count into 1..USE_BUCKETS and hold the last index
   always_comb begin
      priority if (bucket_count_ff == '0) begin
         last_bkt = '0;
      end else if (bucket_count_ff > BCNT_W'(USE_BUCKETS)) begin
         last_bkt = CNT_AW'(USE_BUCKETS - 1);
      end else begin
         last_bkt = CNT_AW'(bucket_count_ff - BCNT_W'(1));
      end
   end

   ssbp_front #(
      .NUM_SPL (NUM_SPL),
      .CNT_AW  (CNT_AW)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_mode           (req_mode),
      .req_splitter_index (req_splitter_index),
      .req_value          (req_value),
      .last_bkt           (last_bkt),
      .job_push           (job_push),
      .job_full           (job_full),
      .job                (job_wr)
   );

   ssbp_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (MID_DEPTH)
   ) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .full    (job_full),
      .wr_data (job_wr),
      .pop     (job_pop),
      .empty   (job_empty),
      .rd_data (job_rd)
   );

   ssbp_back #(
      .USE_BUCKETS (USE_BUCKETS),
      .CNT_AW      (CNT_AW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .last_bkt  (last_bkt),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job       (job_rd),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_wr)
   );

   ssbp_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .full    (out_full),
      .wr_data (out_wr),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (out_rd)
   );

   assign rsp_kind   = out_rd.kind;
   assign rsp_bucket = out_rd.bucket;
   assign rsp_count  = out_rd.count;
   assign rsp_offset = out_rd.offset;
   assign rsp_last   = out_rd.last;

endmodule

// File: rtl/ssbp_checker.sv
// Port-level checks on the partitioner result channel, bound to the top level.
// Uses ssbp_pkg.
`timescale 1ns / 1ps

module ssbp_checker
   import ssbp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input logic              rsp_kind,
   input logic [BKT_W-1:0]  rsp_bucket,
   input logic [DATA_W-1:0] rsp_count,
   input logic [DATA_W-1:0] rsp_offset,
   input logic              rsp_last
);

   a_reset_empties: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_classify_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_CLASSIFY) |-> (rsp_offset == '0 && rsp_last))
      else $error("classification result with offset or without last");

   a_first_offset: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_REPORT && rsp_bucket == '0) |-> (rsp_offset == '0))
      else $error("report entry for bucket zero with nonzero offset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_kind) && $stable(rsp_bucket)
         && $stable(rsp_count) && $stable(rsp_offset) && $stable(rsp_last)))
      else $error("waiting result changed or vanished");

endmodule

bind sample_sort_bucket_partitioner_top ssbp_checker u_ssbp_checker (.*);
